[hdl/pbso_pkg.sv]
// Shared types and constants for the PolyBLEP saw/pulse oscillator.
// Holds the microcode program, control structs and register codes.
// No dependencies.
package pbso_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PHASE_INC  = 2'd0,
      CSR_PWM_WIDTH  = 2'd1,
      CSR_DUTY_LOW   = 2'd2,
      CSR_DUTY_HIGH  = 2'd3
   } csr_index_type;

   localparam logic [23:0] PHASE_INC_RESET = 24'd0;
   localparam logic [15:0] PWM_WIDTH_RESET = 16'd0;
   localparam logic [23:0] DUTY_LOW_RESET  = 24'd838861;
   localparam logic [23:0] DUTY_HIGH_RESET = 24'd8388608;

   typedef struct packed {
      logic [23:0] phase_increment;
      logic [15:0] pwm_width;
      logic [23:0] duty_low;
      logic [23:0] duty_high;
   } cfg_type;

   // datapath operations, one per microcode step
   typedef enum logic [3:0] {
      OP_START,
      OP_MUL_LO,
      OP_DUTY,
      OP_DUTY_DT,
      OP_SETUP_A,
      OP_SETUP_B,
      OP_DIV,
      OP_SQ_A,
      OP_SQ_B,
      OP_BLEP_B,
      OP_MIX,
      OP_OUT
   } op_type;

   // sequencing: fall through, wait for a request, count loop, wait for output slot
   typedef enum logic [1:0] {
      COND_NEXT,
      COND_REQ,
      COND_CNT,
      COND_OUT
   } cond_type;

   typedef logic [3:0] step_type;

   localparam step_type STEP_IDLE    = 4'd0;
   localparam step_type STEP_MUL_LO  = 4'd1;
   localparam step_type STEP_DUTY    = 4'd2;
   localparam step_type STEP_DUTY_DT = 4'd3;
   localparam step_type STEP_SETUP_A = 4'd4;
   localparam step_type STEP_SETUP_B = 4'd5;
   localparam step_type STEP_DIV     = 4'd6;
   localparam step_type STEP_SQ_A    = 4'd7;
   localparam step_type STEP_SQ_B    = 4'd8;
   localparam step_type STEP_BLEP_B  = 4'd9;
   localparam step_type STEP_MIX     = 4'd10;
   localparam step_type STEP_OUT     = 4'd11;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
      logic     cnt_load;
   } uword_type;

   typedef struct packed {
      op_type op;
      logic   fire;
   } dp_ctl_type;

   // microcode ROM
   function automatic uword_type micro_word(input step_type step);
      uword_type w;
      w = '{op: OP_START, cond: COND_REQ, target: STEP_IDLE, cnt_load: 1'b0};
      case (step)
         STEP_IDLE:    w = '{op: OP_START,   cond: COND_REQ,  target: STEP_IDLE, cnt_load: 1'b0};
         STEP_MUL_LO:  w = '{op: OP_MUL_LO,  cond: COND_NEXT, target: STEP_IDLE, cnt_load: 1'b0};
         STEP_DUTY:    w = '{op: OP_DUTY,    cond: COND_NEXT, target: STEP_IDLE, cnt_load: 1'b0};
         STEP_DUTY_DT: w = '{op: OP_DUTY_DT, cond: COND_NEXT, target: STEP_IDLE, cnt_load: 1'b0};
         STEP_SETUP_A: w = '{op: OP_SETUP_A, cond: COND_NEXT, target: STEP_IDLE, cnt_load: 1'b0};
         STEP_SETUP_B: w = '{op: OP_SETUP_B, cond: COND_NEXT, target: STEP_IDLE, cnt_load: 1'b1};
         STEP_DIV:     w = '{op: OP_DIV,     cond: COND_CNT,  target: STEP_DIV,  cnt_load: 1'b0};
         STEP_SQ_A:    w = '{op: OP_SQ_A,    cond: COND_NEXT, target: STEP_IDLE, cnt_load: 1'b0};
         STEP_SQ_B:    w = '{op: OP_SQ_B,    cond: COND_NEXT, target: STEP_IDLE, cnt_load: 1'b0};
         STEP_BLEP_B:  w = '{op: OP_BLEP_B,  cond: COND_NEXT, target: STEP_IDLE, cnt_load: 1'b0};
         STEP_MIX:     w = '{op: OP_MIX,     cond: COND_NEXT, target: STEP_IDLE, cnt_load: 1'b0};
         STEP_OUT:     w = '{op: OP_OUT,     cond: COND_OUT,  target: STEP_IDLE, cnt_load: 1'b0};
         default:      w = '{op: OP_START,   cond: COND_REQ,  target: STEP_IDLE, cnt_load: 1'b0};
      endcase
      return w;
   endfunction

endpackage

[hdl/pbso_stream_ifs.sv]
// Valid/ready channel interfaces for the oscillator: sample tick requests
// and sample results. No dependencies.
interface pbso_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface pbso_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] saw_sample;
   logic signed [SAMPLE_BITS-1:0] pulse_sample;

   modport source (output valid, output saw_sample, output pulse_sample, input ready);
   modport sink   (input valid, input saw_sample, input pulse_sample, output ready);
endinterface

[hdl/pbso_datapath.sv]
// Oscillator datapath: phase accumulator, duty mapping, shared multiplier,
// two bit-serial divider lanes and output rounding. Uses pbso_pkg.
module pbso_datapath #(
   parameter int PHASE_BITS  = 24,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pbso_pkg::dp_ctl_type          ctl,
   input  pbso_pkg::cfg_type             cfg,
   input  logic                          restart,
   output logic signed [SAMPLE_BITS-1:0] saw_sample,
   output logic signed [SAMPLE_BITS-1:0] pulse_sample
);
   import pbso_pkg::*;

   localparam int P    = PHASE_BITS;
   localparam int MW   = (P > 24) ? P : 24;
   localparam int PW   = 2 * MW;
   localparam int SW   = P + 3;
   localparam int BW   = P + 2;
   localparam int UP   = (P >= 24) ? P - 24 : 0;
   localparam int DN   = (P < 24) ? 24 - P : 0;
   localparam int FB   = SAMPLE_BITS - 2;
   localparam int SH_R = (P >= FB) ? P - FB : 0;
   localparam int SH_L = (P < FB) ? FB - P : 0;
   localparam int XW   = (P >= FB) ? P + 4 : FB + 4;

   localparam logic [P:0]           ONE_Q    = (P+1)'(1) << P;
   localparam logic [P-1:0]         HALF_ONE = P'(1) << (P - 1);
   localparam logic signed [SW-1:0] ONE_S    = SW'(ONE_Q);
   localparam logic signed [XW-1:0] HALF_R   = XW'((2 ** SH_R) / 2);
   localparam logic signed [XW-1:0] SMAX     = XW'((2 ** (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [XW-1:0] SMIN     = -SMAX - XW'(1);

   typedef struct packed {
      logic         act;
      logic         neg;
      logic [P-1:0] rem;
   } lane_type;

   function automatic logic [P-1:0] from_q24(input logic [23:0] v);
      logic [MW-1:0] w;
      w = MW'(v) << UP;
      w = w >> DN;
      return P'(w);
   endfunction

   // pick the BLEP side for phase x and the numerator of its division
   function automatic lane_type lane_setup(input logic [P-1:0] x, input logic [P-1:0] dt);
      lane_type   l;
      logic [P:0] lim;
      lim   = ONE_Q - {1'b0, dt};
      l.act = 1'b0;
      l.neg = 1'b0;
      l.rem = x;
      if (x < dt) begin
         l.act = 1'b1;
         l.neg = 1'b1;
         l.rem = x;
      end else if ({1'b0, x} > lim) begin
         l.act = 1'b1;
         l.neg = 1'b0;
         l.rem = P'(ONE_Q - {1'b0, x});
      end
      return l;
   endfunction

   function automatic logic signed [BW-1:0] blep_value(input logic act, input logic neg,
                                                       input logic [P-1:0] quo,
                                                       input logic [P-1:0] sq);
      logic [P:0]           mag;
      logic signed [BW-1:0] val;
      mag = (quo == '0) ? ONE_Q : {1'b0, sq};
      val = $signed({1'b0, mag});
      if (!act) begin
         val = '0;
      end else if (neg) begin
         val = -val;
      end
      return val;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] to_sample(input logic signed [SW-1:0] v);
      logic signed [XW-1:0] x;
      x = XW'(v);
      x = ((x + HALF_R) >>> SH_R) <<< SH_L;
      if (x > SMAX) begin
         x = SMAX;
      end else if (x < SMIN) begin
         x = SMIN;
      end
      return SAMPLE_BITS'(x);
   endfunction

   logic [P-1:0]            dt_ff, dt_in;
   logic                    restart_ff;
   logic [P-1:0]            phase_ff;
   logic [PW-1:0]           acc_ff;
   logic [PW-1:0]           prod_ff;
   logic [P-1:0]            duty_ff, duty_in;
   logic [P-1:0]            td_ff;
   lane_type                lane_a_ff, lane_a_in;
   lane_type                lane_b_ff, lane_b_in;
   logic [P-1:0]            quo_a_ff, quo_b_ff;
   logic signed [BW-1:0]    ba_ff, bb_ff;
   logic signed [SW-1:0]    saw_mix_ff, pulse_mix_ff;
   logic signed [SAMPLE_BITS-1:0] saw_out_ff, pulse_out_ff;

   logic [MW-1:0]           mul_a, mul_b;
   logic [PW-1:0]           mul_p;
   logic [P:0]              sq_v;
   logic [PW-1:0]           duty_sum;
   logic [23:0]             duty_raw;
   logic [P:0]              phase_sum;
   logic [P:0]              div_a2, div_b2;
   logic signed [SW-1:0]    saw_in, pulse_in;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      sq_v  = '0;
      case (ctl.op)
         OP_START: begin
            mul_a = MW'(cfg.duty_high);
            mul_b = MW'({1'b1, 16'h0000} - {1'b0, cfg.pwm_width});
         end
         OP_MUL_LO: begin
            mul_a = MW'(cfg.duty_low);
            mul_b = MW'(cfg.pwm_width);
         end
         OP_SQ_A: begin
            sq_v  = ONE_Q - {1'b0, quo_a_ff};
            mul_a = MW'(sq_v[P-1:0]);
            mul_b = MW'(sq_v[P-1:0]);
         end
         OP_SQ_B: begin
            sq_v  = ONE_Q - {1'b0, quo_b_ff};
            mul_a = MW'(sq_v[P-1:0]);
            mul_b = MW'(sq_v[P-1:0]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      dt_in = from_q24(cfg.phase_increment);
      if (dt_in > HALF_ONE) begin
         dt_in = HALF_ONE;
      end

      duty_sum = acc_ff + prod_ff;
      duty_raw = duty_sum[16 +: 24];
      if (duty_raw < cfg.duty_low) begin
         duty_raw = cfg.duty_low;
      end
      if (duty_raw > cfg.duty_high) begin
         duty_raw = cfg.duty_high;
      end

      // keep both pulse edges at least one step away from each other
      duty_in = (duty_ff < dt_ff) ? dt_ff : duty_ff;
      if ((ONE_Q - {1'b0, duty_in}) < {1'b0, dt_ff}) begin
         duty_in = P'(ONE_Q - {1'b0, dt_ff});
      end

      phase_sum = {1'b0, (restart_ff ? '0 : phase_ff)} + {1'b0, dt_ff};

      lane_a_in = lane_setup(phase_ff, dt_ff);
      lane_b_in = lane_setup(td_ff, dt_ff);

      div_a2 = {lane_a_ff.rem, 1'b0};
      div_b2 = {lane_b_ff.rem, 1'b0};

      saw_in   = $signed({2'b00, phase_ff, 1'b0}) - ONE_S - SW'(ba_ff);
      pulse_in = ((phase_ff < duty_ff) ? ONE_S : -ONE_S) + SW'(ba_ff) - SW'(bb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (ctl.fire && ctl.op == OP_MUL_LO) begin
         // advance and wrap modulo one
         phase_ff <= phase_sum[P-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         case (ctl.op)
            OP_START: begin
               dt_ff      <= dt_in;
               restart_ff <= restart;
               prod_ff    <= mul_p;
            end
            OP_MUL_LO: begin
               acc_ff  <= prod_ff;
               prod_ff <= mul_p;
            end
            OP_DUTY: begin
               duty_ff <= from_q24(duty_raw);
            end
            OP_DUTY_DT: begin
               duty_ff <= duty_in;
            end
            OP_SETUP_A: begin
               lane_a_ff <= lane_a_in;
               quo_a_ff  <= '0;
               td_ff     <= phase_ff - duty_ff;
            end
            OP_SETUP_B: begin
               lane_b_ff <= lane_b_in;
               quo_b_ff  <= '0;
            end
            OP_DIV: begin
               // one restoring quotient bit per lane
               if (div_a2 >= {1'b0, dt_ff}) begin
                  lane_a_ff.rem <= P'(div_a2 - {1'b0, dt_ff});
                  quo_a_ff      <= {quo_a_ff[P-2:0], 1'b1};
               end else begin
                  lane_a_ff.rem <= div_a2[P-1:0];
                  quo_a_ff      <= {quo_a_ff[P-2:0], 1'b0};
               end
               if (div_b2 >= {1'b0, dt_ff}) begin
                  lane_b_ff.rem <= P'(div_b2 - {1'b0, dt_ff});
                  quo_b_ff      <= {quo_b_ff[P-2:0], 1'b1};
               end else begin
                  lane_b_ff.rem <= div_b2[P-1:0];
                  quo_b_ff      <= {quo_b_ff[P-2:0], 1'b0};
               end
            end
            OP_SQ_A: begin
               prod_ff <= mul_p;
            end
            OP_SQ_B: begin
               ba_ff   <= blep_value(lane_a_ff.act, lane_a_ff.neg, quo_a_ff, prod_ff[P +: P]);
               prod_ff <= mul_p;
            end
            OP_BLEP_B: begin
               bb_ff <= blep_value(lane_b_ff.act, lane_b_ff.neg, quo_b_ff, prod_ff[P +: P]);
            end
            OP_MIX: begin
               saw_mix_ff   <= saw_in;
               pulse_mix_ff <= pulse_in;
            end
            OP_OUT: begin
               saw_out_ff   <= to_sample(saw_mix_ff);
               pulse_out_ff <= to_sample(pulse_mix_ff);
            end
            default: begin
               acc_ff <= acc_ff;
            end
         endcase
      end
   end

   assign saw_sample   = saw_out_ff;
   assign pulse_sample = pulse_out_ff;

endmodule

[hdl/polyblep_saw_pulse_oscillator.sv]
// Top level of the PolyBLEP saw/pulse oscillator: configuration registers,
// microcode sequencer and result register. Uses pbso_pkg, pbso_stream_ifs,
// pbso_datapath.
//
// Usage: every transfer on req_ch is one sample tick; restart clears the
// phase before the tick's advance. Each tick produces exactly one transfer
// on rsp_ch carrying a band-limited sawtooth and a band-limited pulse,
// signed Q2.(SAMPLE_BITS-2), saturated.
// Registers are written through csr_wr_en/csr_index/csr_wdata: 0 phase
// increment, 1 PWM width, 2 duty low, 3 duty high. The user must write
// them only while the block is idle; the block itself does not enforce it.
// The sequencer takes a request at its idle step, then runs the multiply,
// duty, lane setup, division, square, BLEP, mix and output steps; one tick
// is processed at a time. The restoring division yields one quotient bit
// per cycle, with the two BLEP divisions running in parallel lanes.
// A finished result waits in the output register while the next tick is
// taken and computed; if rsp_ch is still stalled when that tick finishes,
// the sequencer holds at its last step until the register frees.
// Reset clears the phase, loads the register defaults and returns the
// sequencer to its idle step with no result pending.
module polyblep_saw_pulse_oscillator #(
   parameter int PHASE_BITS  = 24,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pbso_req_if.sink                             req_ch,
   pbso_rsp_if.source                           rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [pbso_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pbso_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import pbso_pkg::*;

   localparam int CW = $clog2(PHASE_BITS + 1);

   cfg_type        cfg_ff;
   step_type       pc_ff, pc_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   uword_type      uw;
   dp_ctl_type     ctl;
   logic           accept;
   logic           slot_free;

   assign uw        = micro_word(pc_ff);
   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      ctl.op   = uw.op;
      ctl.fire = 1'b1;
      pc_in    = pc_ff + 4'd1;
      case (uw.cond)
         COND_REQ: begin
            ctl.fire = accept;
            pc_in    = accept ? pc_ff + 4'd1 : pc_ff;
         end
         COND_CNT: begin
            pc_in = (cnt_ff != CW'(1)) ? uw.target : pc_ff + 4'd1;
         end
         COND_OUT: begin
            ctl.fire = slot_free;
            pc_in    = slot_free ? uw.target : pc_ff;
         end
         default: begin
            pc_in = pc_ff + 4'd1;
         end
      endcase

      cnt_in = cnt_ff;
      if (uw.cnt_load) begin
         cnt_in = CW'(PHASE_BITS);
      end else if (uw.cond == COND_CNT) begin
         cnt_in = cnt_ff - CW'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      if (ctl.fire && uw.op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff                  <= STEP_IDLE;
         cnt_ff                 <= '0;
         rsp_valid_ff           <= 1'b0;
         cfg_ff.phase_increment <= PHASE_INC_RESET;
         cfg_ff.pwm_width       <= PWM_WIDTH_RESET;
         cfg_ff.duty_low        <= DUTY_LOW_RESET;
         cfg_ff.duty_high       <= DUTY_HIGH_RESET;
      end else begin
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_PHASE_INC: cfg_ff.phase_increment <= csr_wdata;
               CSR_PWM_WIDTH: cfg_ff.pwm_width       <= csr_wdata[15:0];
               CSR_DUTY_LOW:  cfg_ff.duty_low        <= csr_wdata;
               CSR_DUTY_HIGH: cfg_ff.duty_high       <= csr_wdata;
               default:       cfg_ff                 <= cfg_ff;
            endcase
         end
      end
   end

   assign req_ch.ready = (pc_ff == STEP_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;

   pbso_datapath #(
      .PHASE_BITS  (PHASE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .cfg          (cfg_ff),
      .restart      (req_ch.restart),
      .saw_sample   (rsp_ch.saw_sample),
      .pulse_sample (rsp_ch.pulse_sample)
   );

endmodule
